>>> hw/rtl/rlc_pkg.sv
// Shared types and codes of the rectangle list coalescer.
// No dependencies.
`default_nettype none
package rlc_pkg;
    localparam logic [1:0] FUNC_JOIN  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [2:0] OUT_APPENDED  = 3'd0;
    localparam logic [2:0] OUT_CONTAINED = 3'd1;
    localparam logic [2:0] OUT_MERGED    = 3'd2;
    localparam logic [2:0] OUT_DROPPED   = 3'd3;
    localparam logic [2:0] OUT_DONE      = 3'd4;

    // Key part of a rectangle: kind, file, sheet key and sheet span
    typedef struct packed {
        logic        ext;
        logic [15:0] file;
        logic [15:0] key;
        logic [11:0] tab_first;
        logic [11:0] tab_last;
    } key_t;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
    } col_span_t;

    typedef struct packed {
        logic [23:0] first;
        logic [23:0] last;
    } row_span_t;

    typedef struct packed {
        key_t      k;
        col_span_t c;
        row_span_t r;
    } rect_t;
endpackage
`default_nettype wire

>>> hw/rtl/rlc_cell.sv
// One table cell of the coalescer: holds an entry and compares it against the
// rectangle presented. Depends on rlc_pkg.
`default_nettype none
module rlc_cell
    import rlc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load,
    input  wire rect_t load_data,
    input  wire logic  widen_col,
    input  wire logic  widen_row,
    input  wire rect_t probe,
    output rect_t      entry,
    output logic       hit_contain,
    output logic       hit_col,
    output logic       hit_row,
    output col_span_t  col_wide,
    output row_span_t  row_wide
);
    rect_t entry_reg;
    logic  key_eq;

    assign entry = entry_reg;

    // Touch test: spans overlap or are adjacent
    function automatic logic touch(input logic [23:0] af, input logic [23:0] al,
                                   input logic [23:0] bf, input logic [23:0] bl);
        logic a1;
        logic a2;
        a1 = (af > bl) && ((af - bl) > 24'd1);
        a2 = (bf > al) && ((bf - al) > 24'd1);
        return !(a1 || a2);
    endfunction

    // Compare probe against the held entry
    always_comb
    begin
        key_eq = (entry_reg.k == probe.k);
        hit_contain = key_eq &&
            entry_reg.r.first <= probe.r.first && probe.r.last <= entry_reg.r.last &&
            entry_reg.c.first <= probe.c.first && probe.c.last <= entry_reg.c.last;
        hit_col = key_eq && probe.r == entry_reg.r &&
            touch({8'd0, probe.c.first}, {8'd0, probe.c.last},
                  {8'd0, entry_reg.c.first}, {8'd0, entry_reg.c.last});
        hit_row = key_eq && probe.r != entry_reg.r && probe.c == entry_reg.c &&
            touch(probe.r.first, probe.r.last, entry_reg.r.first, entry_reg.r.last);
        col_wide.first = (probe.c.first < entry_reg.c.first) ? probe.c.first
                                                             : entry_reg.c.first;
        col_wide.last  = (probe.c.last > entry_reg.c.last) ? probe.c.last
                                                           : entry_reg.c.last;
        row_wide.first = (probe.r.first < entry_reg.r.first) ? probe.r.first
                                                             : entry_reg.r.first;
        row_wide.last  = (probe.r.last > entry_reg.r.last) ? probe.r.last
                                                           : entry_reg.r.last;
    end

    // Hold, load or widen the entry
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= load_data;
        end
        else if (widen_col)
        begin
            entry_reg.c <= col_wide;
        end
        else if (widen_row)
        begin
            entry_reg.r <= row_wide;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/rectangle_list_coalescer.sv
// Top level of the rectangle list coalescer: row of rlc_cell entries and the
// scan sequencer. Depends on rlc_pkg and rlc_cell.
//
// Usage: one command word enters on the input channel (in_valid/in_ready) and
// exactly one result word leaves on the output channel (out_valid/out_ready).
// A join scans the table one entry a cycle in order: a pass stops at the first
// entry that contains or merges the rectangle, or else runs past the last entry,
// where it appends or drops. A merge with more than one entry in the table pops
// the tail entry and starts a fresh pass with it, so each rejoin adds another
// pass. After the scan S_FINISH registers the result and S_WAIT loads it into
// the output register; read, clear and the unused code skip the scan and go
// straight to S_FINISH. The sequencer takes one word at a time and is ready
// again in the cycle after the result is loaded. While the receiver stalls, a
// result still held in the output register blocks the next result, and the
// input stays blocked until it is taken. Reset empties the table (count zero);
// entry contents are not cleared and are never shown before they are written.
`default_nettype none
module rectangle_list_coalescer
    import rlc_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int COL_BITS    = 14,
    parameter int ROW_BITS    = 20,
    parameter int TAB_BITS    = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [3:0]  entry_index,
    input  wire logic        is_external,
    input  wire logic [15:0] file_id,
    input  wire logic [15:0] sheet_key,
    input  wire logic [7:0]  tab_first,
    input  wire logic [7:0]  tab_last,
    input  wire logic [13:0] col_first,
    input  wire logic [13:0] col_last,
    input  wire logic [19:0] row_first,
    input  wire logic [19:0] row_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       outcome,
    output logic [4:0]       entry_count,
    output logic             out_external,
    output logic [15:0]      out_file_id,
    output logic [15:0]      out_sheet_key,
    output logic [7:0]       out_tab_first,
    output logic [7:0]       out_tab_last,
    output logic [13:0]      out_col_first,
    output logic [13:0]      out_col_last,
    output logic [19:0]      out_row_first,
    output logic [19:0]      out_row_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_FINISH, S_WAIT } state_t;

    state_t                state_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         idx_reg;
    logic [1:0]            func_reg;
    logic [3:0]            ridx_reg;
    rect_t                 cur_reg;
    logic [2:0]            top_reg;
    logic                  have_top_reg;
    logic [2:0]            res_reg;
    rect_t                 rd_reg;

    rect_t                 entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hc, hcol, hrow, ld, wc, wr;
    col_span_t             cws [TABLE_DEPTH];
    row_span_t             rws [TABLE_DEPTH];
    rect_t                 in_rect;
    rect_t                 ld_data;
    rect_t                 pop_rect;
    logic [IW-1:0]         idx_sel;
    logic [IW-1:0]         pop_sel;
    logic                  scan_end;
    logic                  hit_any;

    // Mask the incoming rectangle to the configured widths; file and key are zero unless external
    always_comb
    begin
        in_rect = '0;
        in_rect.k.ext = is_external;
        in_rect.k.file = is_external ? file_id : 16'd0;
        in_rect.k.key = is_external ? sheet_key : 16'd0;
        in_rect.k.tab_first = 12'(tab_first) & 12'((1 << TAB_BITS) - 1);
        in_rect.k.tab_last  = 12'(tab_last) & 12'((1 << TAB_BITS) - 1);
        in_rect.c.first = 16'(col_first) & 16'((1 << COL_BITS) - 1);
        in_rect.c.last  = 16'(col_last) & 16'((1 << COL_BITS) - 1);
        in_rect.r.first = 24'(row_first) & 24'((1 << ROW_BITS) - 1);
        in_rect.r.last  = 24'(row_last) & 24'((1 << ROW_BITS) - 1);
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            rlc_cell u_cell (
                .clk         (clk),
                .load        (ld[g]),
                .load_data   (ld_data),
                .widen_col   (wc[g]),
                .widen_row   (wr[g]),
                .probe       (cur_reg),
                .entry       (entries[g]),
                .hit_contain (hc[g]),
                .hit_col     (hcol[g]),
                .hit_row     (hrow[g]),
                .col_wide    (cws[g]),
                .row_wide    (rws[g])
            );
        end
    endgenerate

    // Scan control: the entry under test is idx_reg
    always_comb
    begin
        ld_data  = cur_reg;
        ld       = '0;
        wc       = '0;
        wr       = '0;
        idx_sel  = idx_reg[IW-1:0];
        scan_end = (idx_reg >= count_reg);
        hit_any  = 1'b0;
        if (state_reg == S_SCAN && !scan_end)
        begin
            hit_any = hc[idx_sel] || hcol[idx_sel] || hrow[idx_sel];
            if (!hc[idx_sel])
            begin
                wc[idx_sel] = hcol[idx_sel];
                wr[idx_sel] = hrow[idx_sel];
            end
        end
        if (state_reg == S_SCAN && scan_end && count_reg < CW'(TABLE_DEPTH))
        begin
            ld[count_reg[IW-1:0]] = 1'b1;
        end
        // Tail entry to rejoin, with the widening of this cycle applied
        pop_sel  = IW'(count_reg - 1'b1);
        pop_rect = entries[pop_sel];
        if (wc[pop_sel])
        begin
            pop_rect.c = cws[pop_sel];
        end
        if (wr[pop_sel])
        begin
            pop_rect.r = rws[pop_sel];
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid     <= 1'b0;
            have_top_reg  <= 1'b0;
            idx_reg       <= '0;
            func_reg      <= FUNC_JOIN;
            ridx_reg      <= '0;
            cur_reg       <= '0;
            rd_reg        <= '0;
            top_reg       <= OUT_APPENDED;
            res_reg       <= OUT_APPENDED;
            outcome       <= OUT_APPENDED;
            entry_count   <= '0;
            out_external  <= 1'b0;
            out_file_id   <= '0;
            out_sheet_key <= '0;
            out_tab_first <= '0;
            out_tab_last  <= '0;
            out_col_first <= '0;
            out_col_last  <= '0;
            out_row_first <= '0;
            out_row_last  <= '0;
        end
        else
        begin
            // Drop the result word once taken, unless a new one replaces it
            if (out_valid && out_ready && state_reg != S_WAIT)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg     <= func;
                        ridx_reg     <= entry_index;
                        cur_reg      <= in_rect;
                        idx_reg      <= '0;
                        have_top_reg <= 1'b0;
                        state_reg    <= (func == FUNC_JOIN) ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN:
                begin
                    if (scan_end || hit_any)
                    begin
                        // Settle the result of this pass
                        logic [2:0]    res;
                        logic [CW-1:0] cnt;
                        res = OUT_APPENDED;
                        cnt = count_reg;
                        if (!scan_end)
                        begin
                            res = hc[idx_sel] ? OUT_CONTAINED : OUT_MERGED;
                        end
                        else if (count_reg >= CW'(TABLE_DEPTH))
                        begin
                            res = OUT_DROPPED;
                        end
                        else
                        begin
                            cnt = count_reg + 1'b1;
                        end
                        if (!have_top_reg)
                        begin
                            top_reg      <= res;
                            have_top_reg <= 1'b1;
                        end
                        idx_reg <= '0;
                        if (res != OUT_MERGED || cnt <= CW'(1))
                        begin
                            count_reg <= cnt;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            // Pop the last entry and join it again
                            count_reg <= cnt - 1'b1;
                            cur_reg   <= pop_rect;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    rd_reg <= '0;
                    if (func_reg == FUNC_JOIN)
                    begin
                        res_reg <= top_reg;
                    end
                    else
                    begin
                        res_reg <= OUT_DONE;
                        if (func_reg == FUNC_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        if (func_reg == FUNC_READ && 32'(ridx_reg) < 32'(count_reg)
                            && 32'(ridx_reg) < TABLE_DEPTH)
                        begin
                            rd_reg <= entries[IW'(ridx_reg)];
                        end
                    end
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid <= 1'b1;
                        outcome   <= res_reg;
                        entry_count   <= 5'(count_reg);
                        out_external  <= rd_reg.k.ext;
                        out_file_id   <= rd_reg.k.file;
                        out_sheet_key <= rd_reg.k.key;
                        out_tab_first <= 8'(rd_reg.k.tab_first);
                        out_tab_last  <= 8'(rd_reg.k.tab_last);
                        out_col_first <= 14'(rd_reg.c.first);
                        out_col_last  <= 14'(rd_reg.c.last);
                        out_row_first <= 20'(rd_reg.r.first);
                        out_row_last  <= 20'(rd_reg.r.last);
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
